// ----- hdl/sptm_pkg.sv -----
package sptm_pkg;

  localparam int TableDepth = 8;
  localparam int TblIdxW    = $clog2(TableDepth);
  localparam int TblCntW    = $clog2(TableDepth + 1);
  localparam int MaxBytes   = 8;
  localparam int ByteCntW   = 4;
  localparam int IdW        = 64;
  localparam int SelW       = 4;
  localparam int PAddrW     = 3;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_BYTE  = 3'd2;
  localparam logic [2:0] ACT_BIND  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NODEV   = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_BADACK  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_BUSY    = 3'd5;
  localparam logic [2:0] ST_UNEXP   = 3'd6;

  localparam logic       KIND_XFER   = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;

  localparam logic [7:0] CMD_PORT_MASK  = 8'h7f;
  localparam logic [7:0] CMD_WRITE_FLAG = 8'h80;
  localparam logic [7:0] POLL_BYTE      = 8'hff;
  localparam logic [7:0] ACK_READ       = 8'hc0;
  localparam logic [7:0] ACK_WRITE      = 8'h80;

  localparam logic [7:0] RETRY_RESET = 8'd10;

  localparam logic [PAddrW-1:0] ADDR_RETRY_LIMIT = PAddrW'(0);

  typedef struct packed {
    logic        kind;
    logic [3:0]  sel;
    logic        active;
    logic [7:0]  obyte;
    logic [2:0]  status;
    logic [63:0] rdata;
  } res_t;

endpackage

// ----- hdl/spi_port_transaction_master.sv -----
// SPI port transaction master.
// Items arrive on the input channel (in_valid_i / in_stall_o) and results
// leave on the output channel (out_valid_o / out_stall_i); a transfer takes
// place at a clock edge where valid is high and stall is low. Every action
// except the unused codes yields exactly one result: either a byte transfer
// request for the bus or a finished result with a status.
// An item is taken in the idle state and worked in the execute state, so a new
// item is accepted only once the last one has left the execute state. A read or
// write request from idle scans the id table, which lives in a synchronous
// memory with one read port: each entry scanned costs a scan step (address),
// then a match step (compare). The retry limit register sits at address 0 of
// the APB-style port. Reset returns the sequencer to idle, empties the table
// and sets the retry limit to ten. Each result sits in an output register;
// while the receiver stalls, one further item is still accepted and worked up
// to the point of its result, which then waits until the register is free.
module spi_port_transaction_master (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   action_i,
  input  logic [63:0]                  device_id_i,
  input  logic [6:0]                   port_i,
  input  logic [3:0]                   byte_count_i,
  input  logic [63:0]                  write_data_i,
  input  logic [3:0]                   bind_select_i,
  input  logic [7:0]                   bus_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [3:0]                   select_line_o,
  output logic                         select_active_o,
  output logic [7:0]                   out_byte_o,
  output logic [2:0]                   status_o,
  output logic [63:0]                  read_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sptm_pkg::PAddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import sptm_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_SCAN, C_MATCH, C_EXEC} ctl_e;
  typedef enum logic [2:0] {PH_IDLE, PH_RCMD, PH_RPOLL, PH_RDATA, PH_WCMD, PH_WPOLL} phase_e;

  localparam int EntryW = IdW + SelW;

  ctl_e                ctl_q, ctl_d;
  phase_e              phase_q, phase_d;
  logic [3:0]          asel_q, asel_d;
  logic [3:0]          acnt_q, acnt_d;
  logic [3:0]          bidx_q, bidx_d;
  logic [7:0]          poll_q, poll_d;
  logic [63:0]         wbuf_q, wbuf_d;
  logic [63:0]         rbuf_q, rbuf_d;
  logic [TblCntW-1:0]  ecnt_q, ecnt_d;
  logic [TblCntW-1:0]  sidx_q, sidx_d;
  logic                found_q, found_d;
  logic [3:0]          fsel_q, fsel_d;
  logic [7:0]          retry_q, retry_d;
  logic                ovld_q, ovld_d;
  res_t                out_q, out_d;

  logic [2:0]          act_q, act_d;
  logic [63:0]         id_q, id_d;
  logic [6:0]          port_q, port_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [63:0]         wdat_q, wdat_d;
  logic [3:0]          bsel_q, bsel_d;
  logic [7:0]          bbyte_q, bbyte_d;

  logic [EntryW-1:0]   tbl_mem [TableDepth];
  logic [EntryW-1:0]   tbl_rdata_q;
  logic                tbl_we;
  logic [TblIdxW-1:0]  tbl_waddr;
  logic [TblIdxW-1:0]  tbl_raddr;

  logic                out_free;
  logic                res_load;
  res_t                res;
  logic [7:0]          poll_inc;
  logic [7:0]          poll_ack;
  logic [63:0]         rbuf_new;
  logic [3:0]          bidx_inc;

  assign pready   = 1'b1;
  assign prdata   = (paddr == ADDR_RETRY_LIMIT) ? {24'd0, retry_q} : 32'd0;
  assign out_free = !ovld_q || !out_stall_i;
  assign in_stall_o = (ctl_q != C_IDLE);

  assign out_valid_o     = ovld_q;
  assign kind_o          = out_q.kind;
  assign select_line_o   = out_q.sel;
  assign select_active_o = out_q.active;
  assign out_byte_o      = out_q.obyte;
  assign status_o        = out_q.status;
  assign read_data_o     = out_q.rdata;

  assign tbl_raddr = sidx_q[TblIdxW-1:0];
  assign tbl_waddr = ecnt_q[TblIdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= {bsel_q, id_q};
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_comb begin
    ctl_d    = ctl_q;
    phase_d  = phase_q;
    asel_d   = asel_q;
    acnt_d   = acnt_q;
    bidx_d   = bidx_q;
    poll_d   = poll_q;
    wbuf_d   = wbuf_q;
    rbuf_d   = rbuf_q;
    ecnt_d   = ecnt_q;
    sidx_d   = sidx_q;
    found_d  = found_q;
    fsel_d   = fsel_q;
    retry_d  = retry_q;
    act_d    = act_q;
    id_d     = id_q;
    port_d   = port_q;
    cnt_d    = cnt_q;
    wdat_d   = wdat_q;
    bsel_d   = bsel_q;
    bbyte_d  = bbyte_q;
    tbl_we   = 1'b0;
    res_load = 1'b0;
    poll_inc = poll_q + 8'd1;
    poll_ack = (phase_q == PH_RPOLL) ? ACK_READ : ACK_WRITE;
    bidx_inc = bidx_q + 4'd1;
    rbuf_new = rbuf_q | ({56'd0, bbyte_q} << {bidx_q[2:0], 3'b000});
    res.kind   = KIND_FINISH;
    res.sel    = (phase_q != PH_IDLE) ? asel_q : 4'd0;
    res.active = (phase_q != PH_IDLE);
    res.obyte  = 8'd0;
    res.status = ST_OK;
    res.rdata  = 64'd0;

    if (psel && penable && pwrite && (paddr == ADDR_RETRY_LIMIT)) begin
      retry_d = pwdata[7:0];
    end

    case (ctl_q)
      C_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          id_d    = device_id_i;
          port_d  = port_i;
          cnt_d   = (byte_count_i > ByteCntW'(MaxBytes)) ? ByteCntW'(MaxBytes) : byte_count_i;
          wdat_d  = write_data_i;
          bsel_d  = bind_select_i;
          bbyte_d = bus_byte_i;
          if ((action_i == ACT_READ || action_i == ACT_WRITE) && phase_q == PH_IDLE) begin
            sidx_d  = '0;
            found_d = 1'b0;
            ctl_d   = C_SCAN;
          end else begin
            ctl_d = C_EXEC;
          end
        end
      end
      C_SCAN: begin
        if (sidx_q == ecnt_q) begin
          ctl_d = C_EXEC;
        end else begin
          ctl_d = C_MATCH;
        end
      end
      C_MATCH: begin
        if (tbl_rdata_q[IdW-1:0] == id_q) begin
          found_d = 1'b1;
          fsel_d  = tbl_rdata_q[EntryW-1:IdW];
          ctl_d   = C_EXEC;
        end else begin
          sidx_d = sidx_q + TblCntW'(1);
          ctl_d  = C_SCAN;
        end
      end
      C_EXEC: begin
        if (out_free) begin
          ctl_d    = C_IDLE;
          res_load = 1'b1;
          case (act_q)
            ACT_READ, ACT_WRITE: begin
              if (phase_q != PH_IDLE) begin
                res.status = ST_BUSY;
              end else if (!found_q) begin
                res.status = ST_NODEV;
              end else begin
                asel_d     = fsel_q;
                acnt_d     = cnt_q;
                bidx_d     = 4'd0;
                poll_d     = 8'd0;
                rbuf_d     = 64'd0;
                wbuf_d     = wdat_q;
                res.kind   = KIND_XFER;
                res.sel    = fsel_q;
                res.active = 1'b1;
                if (act_q == ACT_READ) begin
                  phase_d   = PH_RCMD;
                  res.obyte = {1'b0, port_q} & CMD_PORT_MASK;
                end else begin
                  phase_d   = PH_WCMD;
                  res.obyte = {1'b0, port_q} | CMD_WRITE_FLAG;
                end
              end
            end
            ACT_BYTE: begin
              res.kind   = KIND_XFER;
              res.sel    = asel_q;
              res.active = 1'b1;
              res.obyte  = POLL_BYTE;
              case (phase_q)
                PH_RCMD: begin
                  poll_d  = 8'd0;
                  phase_d = PH_RPOLL;
                end
                PH_RPOLL, PH_WPOLL: begin
                  poll_d = poll_inc;
                  if (poll_inc == retry_q || (bbyte_q != POLL_BYTE && bbyte_q != poll_ack)) begin
                    phase_d    = PH_IDLE;
                    res.kind   = KIND_FINISH;
                    res.active = 1'b0;
                    res.obyte  = 8'd0;
                    res.status = (poll_inc == retry_q) ? ST_TIMEOUT : ST_BADACK;
                  end else if (bbyte_q == poll_ack) begin
                    if (phase_q == PH_RPOLL && acnt_q != 4'd0) begin
                      bidx_d  = 4'd0;
                      phase_d = PH_RDATA;
                    end else begin
                      phase_d    = PH_IDLE;
                      res.kind   = KIND_FINISH;
                      res.active = 1'b0;
                      res.obyte  = 8'd0;
                      res.rdata  = (phase_q == PH_RPOLL) ? rbuf_q : 64'd0;
                    end
                  end
                end
                PH_RDATA: begin
                  rbuf_d = rbuf_new;
                  bidx_d = bidx_inc;
                  if (bidx_inc >= acnt_q) begin
                    phase_d    = PH_IDLE;
                    res.kind   = KIND_FINISH;
                    res.active = 1'b0;
                    res.obyte  = 8'd0;
                    res.rdata  = rbuf_new;
                  end
                end
                PH_WCMD: begin
                  if (bidx_q < acnt_q) begin
                    res.obyte = wbuf_q[{bidx_q[2:0], 3'b000} +: 8];
                    bidx_d    = bidx_inc;
                  end else begin
                    poll_d  = 8'd0;
                    phase_d = PH_WPOLL;
                  end
                end
                default: begin
                  res.kind   = KIND_FINISH;
                  res.sel    = 4'd0;
                  res.active = 1'b0;
                  res.obyte  = 8'd0;
                  res.status = ST_UNEXP;
                end
              endcase
            end
            ACT_BIND: begin
              if (ecnt_q >= TblCntW'(TableDepth)) begin
                res.status = ST_FULL;
              end else begin
                tbl_we = 1'b1;
                ecnt_d = ecnt_q + TblCntW'(1);
              end
            end
            ACT_CLEAR: begin
              ecnt_d = '0;
            end
            default: begin
              res_load = 1'b0;
            end
          endcase
        end
      end
      default: begin
        ctl_d = C_IDLE;
      end
    endcase

    ovld_d = res_load || (ovld_q && out_stall_i);
    out_d  = res_load ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= C_IDLE;
      phase_q <= PH_IDLE;
      asel_q  <= 4'd0;
      acnt_q  <= 4'd0;
      bidx_q  <= 4'd0;
      poll_q  <= 8'd0;
      wbuf_q  <= 64'd0;
      rbuf_q  <= 64'd0;
      ecnt_q  <= '0;
      sidx_q  <= '0;
      found_q <= 1'b0;
      fsel_q  <= 4'd0;
      retry_q <= RETRY_RESET;
      ovld_q  <= 1'b0;
      out_q   <= '0;
      act_q   <= 3'd0;
      id_q    <= 64'd0;
      port_q  <= 7'd0;
      cnt_q   <= 4'd0;
      wdat_q  <= 64'd0;
      bsel_q  <= 4'd0;
      bbyte_q <= 8'd0;
    end else begin
      ctl_q   <= ctl_d;
      phase_q <= phase_d;
      asel_q  <= asel_d;
      acnt_q  <= acnt_d;
      bidx_q  <= bidx_d;
      poll_q  <= poll_d;
      wbuf_q  <= wbuf_d;
      rbuf_q  <= rbuf_d;
      ecnt_q  <= ecnt_d;
      sidx_q  <= sidx_d;
      found_q <= found_d;
      fsel_q  <= fsel_d;
      retry_q <= retry_d;
      ovld_q  <= ovld_d;
      out_q   <= out_d;
      act_q   <= act_d;
      id_q    <= id_d;
      port_q  <= port_d;
      cnt_q   <= cnt_d;
      wdat_q  <= wdat_d;
      bsel_q  <= bsel_d;
      bbyte_q <= bbyte_d;
    end
  end

endmodule

// ----- hdl/sptm_checker.sv -----
module sptm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [3:0]  select_line_o,
  input logic        select_active_o,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  status_o,
  input logic [63:0] read_data_o
);
  import sptm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(select_line_o)
      && $stable(out_byte_o) && $stable(status_o) && $stable(read_data_o))
    else $error("Stalled result changed.");

  a_xfer_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_XFER |-> select_active_o && status_o == ST_OK
      && read_data_o == 64'd0)
    else $error("Transfer request with bad status, select or data.");

  a_finish_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_FINISH |-> out_byte_o == 8'd0)
    else $error("Finished result carries an output byte.");

  a_rdata_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_data_o != 64'd0 |-> kind_o == KIND_FINISH && status_o == ST_OK
      && !select_active_o)
    else $error("Read data outside an ok finished result.");

endmodule

bind spi_port_transaction_master sptm_checker u_sptm_checker (.*);
